FILE: src/pbrd_pkg.sv
// Shared constants for the pulse beat rate detector.
package pbrd_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 2'd2;

    localparam int THR_W   = 13;
    localparam int REFR_W  = 16;
    localparam int ALPHA_W = 11;
    localparam int TIME_W  = 32;
    localparam int RATE_W  = 24;
    localparam int SMP_FIELD_W = 12;
    localparam int BL_FIELD_W  = 12;

    localparam logic signed [THR_W-1:0] THR_RST = 13'sd100;
    localparam logic [REFR_W-1:0]  REFR_RST  = 16'd250;
    localparam logic [ALPHA_W-1:0] ALPHA_RST = 11'd16;

    // 60000 bpm-ms in Q.8
    localparam logic [RATE_W-1:0] RATE_NUM_Q8 = 24'd15360000;

endpackage

FILE: src/pulse_beat_rate_detector_unit.sv
// Pulse beat rate detector: EMA baseline, threshold beat detection, serial rate divider.
//
// channel   dir  signals                          content
// cfg       in   cfg_valid/ready, index, data     register writes
// s_axis    in   s_tvalid/tready/tdata            sample, time_ms
// m_axis    out  m_tvalid/tready/tdata/tuser      rate_q8, baseline_out; beat
//
// Each sample takes one NUM_W-bit division, or two when a rate is measured (NUM_W is 24
// for 12-bit samples); the restoring divider yields one quotient bit a cycle.
// Reset: control/config state resets at once, no clearing pass; datapath regs have none.
// A held output stalls only the final write-back step; s_tready is high only when idle.
module pulse_beat_rate_detector_unit
    import pbrd_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,   // [11:0] sample, [43:12] time_ms, [47:44] zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,   // [23:0] rate_q8, [35:24] baseline_out, [39:36] zero
    output logic                  m_tuser    // [0] beat
);

    localparam int PROD_W = SAMPLE_BITS + ALPHA_W;
    localparam int NUM_W  = (SAMPLE_BITS + 12 > RATE_W) ? SAMPLE_BITS + 12 : RATE_W;
    localparam int CNT_W  = $clog2(NUM_W + 1);
    localparam int SW     = (SAMPLE_BITS > SMP_FIELD_W) ? SAMPLE_BITS : SMP_FIELD_W;
    localparam int CMP_W  = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 2;
    localparam logic [SAMPLE_BITS-1:0] BL_RST = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_EVAL = 3'd3;
    localparam logic [2:0] ST_RATE = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]               state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [TIME_W-1:0]        rem_reg, rem_next;
    logic [NUM_W-1:0]         quo_reg, quo_next;
    logic [TIME_W-1:0]        dvsr_reg, dvsr_next;
    logic                     div_rate_reg, div_rate_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic [SAMPLE_BITS-1:0]   smp_reg, smp_next;
    logic [TIME_W-1:0]        time_reg, time_next;
    logic [SAMPLE_BITS-1:0]   baseline_reg, baseline_next;
    logic [TIME_W-1:0]        last_beat_reg, last_beat_next;
    logic                     beat_seen_reg, beat_seen_next;
    logic                     was_above_reg, was_above_next;
    logic [RATE_W-1:0]        rate_reg, rate_next;
    logic                     beat_pend_reg, beat_pend_next;
    logic                     m_valid_reg, m_valid_next;
    logic [39:0]              m_data_reg, m_data_next;
    logic                     m_user_reg, m_user_next;

    logic signed [THR_W-1:0]  thr_reg;
    logic [REFR_W-1:0]        refr_reg;
    logic [ALPHA_W-1:0]       alpha_reg;

    logic [ALPHA_W-1:0]       alpha_eff;
    logic [SW-1:0]            smp_in;
    logic [TIME_W:0]          div_shift;
    logic [TIME_W:0]          div_diff;
    logic [SAMPLE_BITS-1:0]   new_bl;
    logic signed [CMP_W-1:0]  cmp_smp;
    logic signed [CMP_W-1:0]  cmp_thr;
    logic                     above;
    logic [TIME_W-1:0]        elapsed;
    logic                     passed;
    logic [SW-1:0]            bl_ext;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    assign alpha_eff = (alpha_reg == '0) ? ALPHA_W'(1) : alpha_reg;
    assign smp_in    = SW'(s_tdata[SMP_FIELD_W-1:0]);

    assign div_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign div_diff  = div_shift - {1'b0, dvsr_reg};

    assign new_bl  = quo_reg[SAMPLE_BITS-1:0];
    assign cmp_smp = signed'(CMP_W'(smp_reg));
    assign cmp_thr = signed'(CMP_W'(new_bl)) + CMP_W'(thr_reg);
    assign above   = cmp_smp > cmp_thr;
    assign elapsed = time_reg - last_beat_reg;
    assign passed  = elapsed > TIME_W'(refr_reg);
    assign bl_ext  = SW'(baseline_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= THR_RST;
            refr_reg  <= REFR_RST;
            alpha_reg <= ALPHA_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_THRESHOLD:  thr_reg   <= signed'(cfg_data[THR_W-1:0]);
                CFG_REFRACTORY: refr_reg  <= cfg_data[REFR_W-1:0];
                CFG_ALPHA:      alpha_reg <= cfg_data[ALPHA_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dvsr_next      = dvsr_reg;
        div_rate_next  = div_rate_reg;
        prod_next      = prod_reg;
        smp_next       = smp_reg;
        time_next      = time_reg;
        baseline_next  = baseline_reg;
        last_beat_next = last_beat_reg;
        beat_seen_next = beat_seen_reg;
        was_above_next = was_above_reg;
        rate_next      = rate_reg;
        beat_pend_next = beat_pend_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    smp_next   = smp_in[SAMPLE_BITS-1:0];
                    time_next  = s_tdata[SMP_FIELD_W +: TIME_W];
                    prod_next  = PROD_W'(baseline_reg * (alpha_eff - ALPHA_W'(1)));
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                quo_next      = NUM_W'(prod_reg) + NUM_W'(smp_reg);
                rem_next      = '0;
                dvsr_next     = TIME_W'(alpha_eff);
                cnt_next      = CNT_W'(NUM_W);
                div_rate_next = 1'b0;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (!div_diff[TIME_W])
                begin
                    rem_next = div_diff[TIME_W-1:0];
                    quo_next = {quo_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = div_shift[TIME_W-1:0];
                    quo_next = {quo_reg[NUM_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = div_rate_reg ? ST_RATE : ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                baseline_next  = new_bl;
                was_above_next = above;
                beat_pend_next = 1'b0;
                state_next     = ST_OUT;
                if (above && !was_above_reg && passed)
                begin
                    beat_seen_next = 1'b1;
                    last_beat_next = time_reg;
                    if (beat_seen_reg)
                    begin
                        beat_pend_next = 1'b1;
                        quo_next       = NUM_W'(RATE_NUM_Q8);
                        rem_next       = '0;
                        dvsr_next      = elapsed;
                        cnt_next       = CNT_W'(NUM_W);
                        div_rate_next  = 1'b1;
                        state_next     = ST_DIV;
                    end
                end
            end
            ST_RATE:
            begin
                rate_next  = quo_reg[RATE_W-1:0];
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'b0, bl_ext[BL_FIELD_W-1:0], rate_reg};
                    m_user_next  = beat_pend_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            div_rate_reg  <= 1'b0;
            baseline_reg  <= BL_RST;
            last_beat_reg <= '0;
            beat_seen_reg <= 1'b0;
            was_above_reg <= 1'b0;
            rate_reg      <= '0;
            beat_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            div_rate_reg  <= div_rate_next;
            baseline_reg  <= baseline_next;
            last_beat_reg <= last_beat_next;
            beat_seen_reg <= beat_seen_next;
            was_above_reg <= was_above_next;
            rate_reg      <= rate_next;
            beat_pend_reg <= beat_pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dvsr_reg   <= dvsr_next;
        prod_reg   <= prod_next;
        smp_reg    <= smp_next;
        time_reg   <= time_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

endmodule

FILE: dv/pulse_rate_checker.sv
// Checker for the pulse beat rate detector: tracks transfers and compares every result.
module pulse_rate_checker
    import pbrd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [47:0]           s_tdata,   // [11:0] sample, [43:12] time_ms, [47:44] zero
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [39:0]           m_tdata,   // [23:0] rate_q8, [35:24] baseline_out, [39:36] zero
    input  logic                  m_tuser,   // [0] beat
    output int                    fails,
    output int                    pending
);

    typedef struct packed {
        logic                  beat;
        logic [RATE_W-1:0]     rate_q8;
        logic [BL_FIELD_W-1:0] baseline;
    } beat_result_t;

    logic signed [THR_W-1:0] thr_offset;
    logic [REFR_W-1:0]       refractory;
    logic [ALPHA_W-1:0]      alpha;

    logic [BL_FIELD_W-1:0]   baseline;
    logic [TIME_W-1:0]       last_beat_time;
    logic                    beat_seen;
    logic                    was_above;
    logic [RATE_W-1:0]       rate_value;

    beat_result_t            expected_beats[$];
    beat_result_t            head;

    // Advances the detector state by one sample and returns the result it gives.
    function automatic beat_result_t detect_beat(input logic [SMP_FIELD_W-1:0] smp,
                                                 input logic [TIME_W-1:0] now);
        longint unsigned a;
        longint unsigned acc;
        int              s_i;
        int              b_i;
        int              t_i;
        logic            above;
        logic            rising;
        logic            passed;
        logic [TIME_W-1:0] elapsed;
        beat_result_t    res;
        a = (alpha == '0) ? 64'd1 : 64'(alpha);
        acc = 64'(baseline) * (a - 64'd1) + 64'(smp);
        baseline = BL_FIELD_W'(acc / a);
        s_i = int'(smp);
        b_i = int'(baseline);
        t_i = int'(thr_offset);
        above = s_i > b_i + t_i;
        rising = above && !was_above;
        elapsed = now - last_beat_time;
        passed = elapsed > TIME_W'(refractory);
        res.beat = 1'b0;
        if (rising && passed)
        begin
            if (beat_seen)
            begin
                rate_value = RATE_W'(TIME_W'(RATE_NUM_Q8) / elapsed);
                res.beat = 1'b1;
            end
            beat_seen = 1'b1;
            last_beat_time = now;
        end
        was_above = above;
        res.rate_q8 = rate_value;
        res.baseline = baseline;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_offset = THR_RST;
            refractory = REFR_RST;
            alpha = ALPHA_RST;
            baseline = BL_FIELD_W'(1) << (BL_FIELD_W - 1);
            last_beat_time = '0;
            beat_seen = 1'b0;
            was_above = 1'b0;
            rate_value = '0;
            expected_beats.delete();
            fails = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_THRESHOLD:  thr_offset = cfg_data[THR_W-1:0];
                    CFG_REFRACTORY: refractory = cfg_data[REFR_W-1:0];
                    CFG_ALPHA:      alpha = cfg_data[ALPHA_W-1:0];
                    default:        ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("result transfer with no result expected");
                    fails++;
                end
                else
                begin
                    head = expected_beats.pop_front();
                    if (m_tuser !== head.beat)
                    begin
                        $error("beat: expected %0d actual %0d", head.beat, m_tuser);
                        fails++;
                    end
                    if (m_tdata[23:0] !== head.rate_q8)
                    begin
                        $error("rate_q8: expected %0d actual %0d", head.rate_q8, m_tdata[23:0]);
                        fails++;
                    end
                    if (m_tdata[35:24] !== head.baseline)
                    begin
                        $error("baseline_out: expected %0d actual %0d",
                               head.baseline, m_tdata[35:24]);
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_beats.push_back(detect_beat(s_tdata[11:0], s_tdata[43:12]));
            pending = expected_beats.size();
        end
    end

endmodule

FILE: dv/pulse_beat_rate_detector_unit_test.sv
// Testbench top for the pulse beat rate detector: clock, reset, stimulus and verdict.
module pulse_beat_rate_detector_unit_test;
    import pbrd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int SETS = 6;
    localparam int ITEMS_PER_SET = 130;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [47:0]           s_tdata;   // [11:0] sample, [43:12] time_ms, [47:44] zero
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [39:0]           m_tdata;   // [23:0] rate_q8, [35:24] baseline_out, [39:36] zero
    logic                  m_tuser;   // [0] beat

    int                    fails;
    int                    pending;
    int                    send_idle_pct;
    int                    recv_idle_pct;

    logic [TIME_W-1:0]     pulse_clock;
    int                    low_left;
    int                    high_left;

    pulse_beat_rate_detector_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    pulse_rate_checker rate_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .fails     (fails),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("FAILED: results differ");
        $finish;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic configure(input int off, input int refr, input int a);
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(off));
        write_reg(CFG_REFRACTORY, CFG_DATA_W'(refr));
        write_reg(CFG_ALPHA, CFG_DATA_W'(a));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(input logic [SMP_FIELD_W-1:0] smp, input logic [TIME_W-1:0] t);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, t, smp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Block is idle once the last sample's result has gone out.
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Pulse train: runs of low samples then a short run of high ones.
    task automatic pulse_item(output logic [SMP_FIELD_W-1:0] smp, output logic [TIME_W-1:0] t);
        pulse_clock += TIME_W'($urandom_range(1, 60));
        if (high_left > 0)
        begin
            smp = SMP_FIELD_W'($urandom_range(2500, 4095));
            high_left--;
            if (high_left == 0)
                low_left = $urandom_range(2, 8);
        end
        else if (low_left > 0)
        begin
            smp = SMP_FIELD_W'($urandom_range(0, 900));
            low_left--;
            if (low_left == 0)
                high_left = $urandom_range(1, 3);
        end
        else
        begin
            smp = '0;
            low_left = 3;
        end
        t = pulse_clock;
    endtask

    initial
    begin
        logic [SMP_FIELD_W-1:0] smp;
        logic [TIME_W-1:0]      t;
        int                     off;
        int                     refr;
        int                     a;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        send_idle_pct = 10;
        recv_idle_pct = 83;
        pulse_clock = $urandom;
        low_left = 0;
        high_left = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: refractory edge, first beat, then a 1000 ms interval
        send_sample(12'd0, 32'd0);
        send_sample(12'd4095, 32'd0);
        send_sample(12'd0, 32'd10);
        send_sample(12'd4095, 32'd250);
        send_sample(12'd0, 32'd260);
        send_sample(12'd4095, 32'd261);
        send_sample(12'd0, 32'd400);
        send_sample(12'd4095, 32'd1261);
        drain();

        // alpha 1024, no refractory: timestamp wrap and the largest rate
        write_reg(CFG_UNUSED, 16'hFFFF);
        configure(0, 0, 1024);
        send_sample(12'd0, 32'hFFFF_FFF0);
        send_sample(12'd4095, 32'hFFFF_FFFF);
        send_sample(12'd0, 32'hFFFF_FFFF);
        send_sample(12'd4095, 32'd0);
        send_sample(12'd0, 32'd3);
        send_sample(12'd4095, 32'd4);
        drain();

        // alpha zero, lowest offset: always above, no new edge
        configure(-4096, 65535, 0);
        send_sample(12'd0, 32'd5);
        send_sample(12'd4095, 32'd70000);
        drain();

        // highest offset: never above
        configure(4095, 65535, 0);
        send_sample(12'd4095, 32'd200000);
        send_sample(12'd0, 32'd300000);
        drain();

        configure(-4096, 65535, 2047);
        send_sample(12'd123, 32'd400000);
        drain();

        // longest refractory: equal elapsed time is rejected, one more is taken
        configure(0, 65535, 2047);
        send_sample(12'd0, 32'd420000);
        send_sample(12'd4095, 32'd465535);
        send_sample(12'd0, 32'd465536);
        send_sample(12'd4095, 32'd465536);
        drain();

        for (int set = 0; set < SETS; set++)
        begin
            if (set == 2)
            begin
                send_idle_pct = 83;
                recv_idle_pct = 10;
            end
            else if (set == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case ($urandom_range(0, 9))
                0:       off = -4096;
                1:       off = 4095;
                default: off = $urandom_range(0, 800) - 200;
            endcase
            case ($urandom_range(0, 9))
                0:       refr = 65535;
                1:       refr = 0;
                default: refr = $urandom_range(0, 600);
            endcase
            case ($urandom_range(0, 9))
                0:       a = 0;
                1:       a = 1024;
                2:       a = 2047;
                default: a = $urandom_range(1, 64);
            endcase
            configure(off, refr, a);
            for (int n = 0; n < ITEMS_PER_SET; n++)
            begin
                if ($urandom_range(0, 99) < 85)
                    pulse_item(smp, t);
                else
                begin
                    smp = SMP_FIELD_W'($urandom_range(0, 4095));
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            t = $urandom;
                            pulse_clock = t;
                        end
                        1:       t = pulse_clock;
                        2:       t = pulse_clock - TIME_W'($urandom_range(0, 500));
                        default: t = pulse_clock + TIME_W'($urandom_range(0, 100000));
                    endcase
                end
                send_sample(smp, t);
            end
            drain();
        end

        repeat (60) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: pulse_beat_rate_detector_unit.f
src/pbrd_pkg.sv
src/pulse_beat_rate_detector_unit.sv
dv/pulse_rate_checker.sv
dv/pulse_beat_rate_detector_unit_test.sv
